>>> hdl/glcw_pkg.sv
// Shared constants and types for the grid line cell walker.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package glcw_pkg;

  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned MAX_SPAN    = 31;
  localparam int unsigned DIFF_BITS   = COORD_BITS + 1;
  localparam int unsigned SPAN_BITS   = $clog2(MAX_SPAN + 1);
  // error term lies within [-MAX_SPAN, 3*MAX_SPAN]
  localparam int unsigned ERR_BITS    = SPAN_BITS + 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_SPAN = 2'd0,
    KIND_LINE = 2'd1,
    KIND_VERT = 2'd2
  } kind_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One classified segment, as handed from the front to the walker.
  typedef struct packed {
    kind_e                kind;
    coord_t               x0;
    coord_t               y0;
    coord_t               stop;   // last column for a line, top y for a vertical run
    logic                 y_dec;  // line steps y downwards
    logic [SPAN_BITS-1:0] adx;
    logic [SPAN_BITS-1:0] ady;
  } cmd_t;

endpackage

>>> hdl/glcw_in_if.sv
// Input channel: one segment (two endpoints) per beat, valid/ready handshake.
// Depends on glcw_pkg for the coordinate width.
interface glcw_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [glcw_pkg::COORD_BITS-1:0] start_x;
  logic signed [glcw_pkg::COORD_BITS-1:0] start_y;
  logic signed [glcw_pkg::COORD_BITS-1:0] end_x;
  logic signed [glcw_pkg::COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> hdl/glcw_out_if.sv
// Output channel: one traversed cell per beat, valid/ready handshake.
// Depends on glcw_pkg for the coordinate width.
interface glcw_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [glcw_pkg::COORD_BITS-1:0] cell_x;
  logic signed [glcw_pkg::COORD_BITS-1:0] cell_y;
  logic                                   last;
  logic                                   span_error;

  modport source (output valid, cell_x, cell_y, last, span_error, input ready);
  modport sink   (input valid, cell_x, cell_y, last, span_error, output ready);
endinterface

>>> hdl/glcw_front.sv
// Front end: takes segment beats, works out spans and walk direction, builds a command.
// Depends on glcw_pkg and glcw_in_if.
module glcw_front (
  glcw_in_if.sink          seg_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output glcw_pkg::cmd_t   q_cmd_o
);

  glcw_pkg::coord_t                     sx, sy, ex, ey;
  logic signed [glcw_pkg::DIFF_BITS-1:0] dx, dy;
  logic [glcw_pkg::DIFF_BITS-1:0]        adx, ady;
  logic                                  too_far;

  assign sx = seg_i.start_x;
  assign sy = seg_i.start_y;
  assign ex = seg_i.end_x;
  assign ey = seg_i.end_y;

  // differences at full precision, no wrap
  assign dx  = {ex[glcw_pkg::COORD_BITS-1], ex} - {sx[glcw_pkg::COORD_BITS-1], sx};
  assign dy  = {ey[glcw_pkg::COORD_BITS-1], ey} - {sy[glcw_pkg::COORD_BITS-1], sy};
  assign adx = dx[glcw_pkg::DIFF_BITS-1] ? glcw_pkg::DIFF_BITS'(-dx)
                                         : glcw_pkg::DIFF_BITS'(dx);
  assign ady = dy[glcw_pkg::DIFF_BITS-1] ? glcw_pkg::DIFF_BITS'(-dy)
                                         : glcw_pkg::DIFF_BITS'(dy);
  assign too_far = (adx > glcw_pkg::DIFF_BITS'(glcw_pkg::MAX_SPAN)) ||
                   (ady > glcw_pkg::DIFF_BITS'(glcw_pkg::MAX_SPAN));

  assign seg_i.ready = !q_full_i;
  assign q_push_o    = seg_i.valid && !q_full_i;

  always_comb begin
    q_cmd_o       = '0;
    q_cmd_o.adx   = adx[glcw_pkg::SPAN_BITS-1:0];
    q_cmd_o.ady   = ady[glcw_pkg::SPAN_BITS-1:0];
    q_cmd_o.y_dec = dx[glcw_pkg::DIFF_BITS-1] ^ dy[glcw_pkg::DIFF_BITS-1];
    if (too_far) begin
      q_cmd_o.kind = glcw_pkg::KIND_SPAN;
    end else if (dx != '0) begin
      q_cmd_o.kind = glcw_pkg::KIND_LINE;
      // walk from the endpoint with the smaller x
      if (sx < ex) begin
        q_cmd_o.x0   = sx;
        q_cmd_o.y0   = sy;
        q_cmd_o.stop = ex;
      end else begin
        q_cmd_o.x0   = ex;
        q_cmd_o.y0   = ey;
        q_cmd_o.stop = sx;
      end
    end else begin
      q_cmd_o.kind = glcw_pkg::KIND_VERT;
      q_cmd_o.x0   = ex;
      q_cmd_o.y0   = (sy < ey) ? sy : ey;
      q_cmd_o.stop = (sy < ey) ? ey : sy;
    end
  end

endmodule

>>> hdl/glcw_queue.sv
// Short command queue between the front end and the walker.
// Depends on glcw_pkg for the command type and depth.
module glcw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  glcw_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output glcw_pkg::cmd_t head_o
);

  glcw_pkg::cmd_t                  slot_q [glcw_pkg::QUEUE_DEPTH];
  logic [glcw_pkg::QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [glcw_pkg::QCNT_BITS-1:0]  count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == glcw_pkg::QCNT_BITS'(glcw_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == glcw_pkg::QPTR_BITS'(glcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == glcw_pkg::QPTR_BITS'(glcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hdl/glcw_back.sv
// Walker: takes commands from the queue and emits one cell beat per cycle while the sink keeps ready high.
// Depends on glcw_pkg and glcw_out_if.
module glcw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  glcw_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  glcw_out_if.source     cell_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COL  = 3'd1;
  localparam logic [2:0] ST_STEP = 3'd2;
  localparam logic [2:0] ST_VERT = 3'd3;
  localparam logic [2:0] ST_SPAN = 3'd4;

  localparam int unsigned EB = glcw_pkg::ERR_BITS;

  logic [2:0]                    state_q, state_d;
  glcw_pkg::coord_t              x_q, x_d, y_q, y_d, stop_q;
  logic signed [EB-1:0]          err_q, err_d;
  logic                          y_dec_q;
  logic [glcw_pkg::SPAN_BITS-1:0] adx_q, ady_q;

  logic                          ovalid_q, ovalid_d;
  glcw_pkg::coord_t              ox_q, ox_d, oy_q, oy_d;
  logic                          olast_q, olast_d, oerr_q, oerr_d;

  logic                          slot_free, load;
  logic signed [EB-1:0]          adx_s, twice_adx, twice_ady, err_add, err_sub;
  glcw_pkg::coord_t              y_stepped;
  logic                          at_stop;

  assign slot_free = !ovalid_q || cell_o.ready;
  assign load      = (state_q == ST_IDLE) && !q_empty_i;
  assign q_pop_o   = load;

  assign adx_s     = signed'(EB'(adx_q));
  assign twice_adx = signed'(EB'({adx_q, 1'b0}));
  assign twice_ady = signed'(EB'({ady_q, 1'b0}));
  assign err_add   = err_q + twice_ady;
  assign err_sub   = err_q - twice_adx;
  assign y_stepped = y_dec_q ? y_q - 1'b1 : y_q + 1'b1;
  assign at_stop   = (x_q == stop_q);

  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    ovalid_d = ovalid_q && !cell_o.ready;
    ox_d     = ox_q;
    oy_d     = oy_q;
    olast_d  = olast_q;
    oerr_d   = oerr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          x_d   = q_head_i.x0;
          y_d   = q_head_i.y0;
          err_d = '0;
          unique case (q_head_i.kind)
            glcw_pkg::KIND_LINE: state_d = ST_COL;
            glcw_pkg::KIND_VERT: state_d = ST_VERT;
            default:             state_d = ST_SPAN;
          endcase
        end
      end
      ST_COL: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ox_d     = x_q;
          oy_d     = y_q;
          oerr_d   = 1'b0;
          olast_d  = 1'b0;
          err_d    = err_add;
          if (err_add >= adx_s) begin
            state_d = ST_STEP;
          end else if (at_stop) begin
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            x_d = x_q + 1'b1;
          end
        end
      end
      ST_STEP: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ox_d     = x_q;
          oy_d     = y_stepped;
          oerr_d   = 1'b0;
          olast_d  = 1'b0;
          y_d      = y_stepped;
          err_d    = err_sub;
          if (err_sub >= adx_s) begin
            state_d = ST_STEP;
          end else if (at_stop) begin
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            x_d     = x_q + 1'b1;
            state_d = ST_COL;
          end
        end
      end
      ST_VERT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ox_d     = x_q;
          oy_d     = y_q;
          oerr_d   = 1'b0;
          olast_d  = (y_q == stop_q);
          if (y_q == stop_q) begin
            state_d = ST_IDLE;
          end else begin
            y_d = y_q + 1'b1;
          end
        end
      end
      ST_SPAN: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ox_d     = '0;
          oy_d     = '0;
          oerr_d   = 1'b1;
          olast_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    err_q   <= err_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
    if (load) begin
      stop_q  <= q_head_i.stop;
      y_dec_q <= q_head_i.y_dec;
      adx_q   <= q_head_i.adx;
      ady_q   <= q_head_i.ady;
    end
  end

  assign cell_o.valid      = ovalid_q;
  assign cell_o.cell_x     = ox_q;
  assign cell_o.cell_y     = oy_q;
  assign cell_o.last       = olast_q;
  assign cell_o.span_error = oerr_q;

endmodule

>>> hdl/grid_line_cell_walk.sv
// Grid line cell walker: for each segment beat, emits the grid cells along it in walk order.
// The front end classifies a segment in the cycle it arrives and parks it in a two-entry
// queue, so new segments are taken while the walker is busy until the queue is full. The
// walker loads a segment from the queue in its idle state, then emits one cell beat per cycle
// through its output register, as long as the sink keeps ready high; a segment whose spans
// stay within MAX_SPAN gives at most 64 cells. A segment with too large a span gives a
// single flagged beat. The last beat of each segment carries last; the cell walk itself
// sets the throughput.
// Depends on glcw_pkg, glcw_in_if, glcw_out_if, glcw_front, glcw_queue and glcw_back.
module grid_line_cell_walk (
  input  logic        clk_i,
  input  logic        rst_ni,
  glcw_in_if.sink     seg_i,
  glcw_out_if.source  cell_o
);

  logic           q_push, q_full, q_pop, q_empty;
  glcw_pkg::cmd_t q_cmd, q_head;

  glcw_front u_front (
    .seg_i    (seg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd)
  );

  glcw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  glcw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .cell_o    (cell_o)
  );

endmodule

>>> tb/grid_line_cell_walk_tb.sv
// Self-checking bench for grid_line_cell_walk: drives segments, predicts every cell beat.
// Depends on glcw_pkg, glcw_in_if, glcw_out_if and the grid_line_cell_walk RTL.
// Sender runs in random bursts; receiver stalls on its own pattern with one long hold-off.
module grid_line_cell_walk_tb;
  import glcw_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned MAX_CELLS   = 64;
  localparam int unsigned RANDOM_SEGS = 400;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    logic   span_error;
  } cell_t;

  class cell_scoreboard;
    cell_t       expected_cells[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_cells.size();
    endfunction

    // Walk one segment, by column or by row if vertical, and queue the cells it yields.
    function void note_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      int    dx;
      int    dy;
      int    adx;
      int    ady;
      int    col;
      int    stop_col;
      int    err;
      int    dir;
      int    y_lo;
      int    y_hi;
      bit    done;
      coord_t row;
      cell_t run[$];
      dx  = int'(ex) - int'(sx);
      dy  = int'(ey) - int'(sy);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      if (adx > int'(MAX_SPAN) || ady > int'(MAX_SPAN)) begin
        expected_cells.push_back('{x: '0, y: '0, last: 1'b1, span_error: 1'b1});
        return;
      end
      if (dx != 0) begin
        if (sx < ex) begin
          col = sx; row = sy; stop_col = ex;
        end else begin
          col = ex; row = ey; stop_col = sx;
        end
        if (dy == 0) dir = 0;
        else dir = ((dx > 0) == (dy > 0)) ? 1 : -1;
        err  = 0;
        done = 1'b0;
        while (!done) begin
          if (run.size() < MAX_CELLS) run.push_back('{coord_t'(col), row, 1'b0, 1'b0});
          err += 2 * ady;
          while (err >= adx) begin
            // y may overshoot the end point and wrap
            row = coord_t'(row + dir);
            err -= 2 * adx;
            if (run.size() < MAX_CELLS) run.push_back('{coord_t'(col), row, 1'b0, 1'b0});
          end
          if (col >= stop_col) done = 1'b1;
          else col++;
        end
      end else begin
        y_lo = sy < ey ? sy : ey;
        y_hi = sy < ey ? ey : sy;
        for (int yy = y_lo; yy <= y_hi; yy++) begin
          if (run.size() < MAX_CELLS) run.push_back('{ex, coord_t'(yy), 1'b0, 1'b0});
        end
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) expected_cells.push_back(run[i]);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_cell(coord_t x, coord_t y, logic last, logic span_err);
      cell_t want;
      string diff;
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d y=%0d last=%b span_error=%b",
                                  x, y, last, span_err));
        return;
      end
      want = expected_cells.pop_front();
      diff = "";
      if (x !== want.x) diff = {diff, $sformatf(" cell_x %0d/%0d", x, want.x)};
      if (y !== want.y) diff = {diff, $sformatf(" cell_y %0d/%0d", y, want.y)};
      if (last !== want.last) diff = {diff, $sformatf(" last %b/%b", last, want.last)};
      if (span_err !== want.span_error)
        diff = {diff, $sformatf(" span_error %b/%b", span_err, want.span_error)};
      if (diff != "") report_mismatch({"got/expected:", diff});
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   hold_req;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned no_gap_left;

  glcw_in_if  seg_ch();
  glcw_out_if cell_ch();

  cell_scoreboard cells_sb = new();

  grid_line_cell_walk DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_ch),
    .cell_o (cell_ch)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Sample both channels on the edge; note the segment before checking any beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (seg_ch.valid && seg_ch.ready)
        cells_sb.note_segment(seg_ch.start_x, seg_ch.start_y, seg_ch.end_x, seg_ch.end_y);
      if (cell_ch.valid && cell_ch.ready)
        cells_sb.check_cell(cell_ch.cell_x, cell_ch.cell_y, cell_ch.last, cell_ch.span_error);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((seg_ch.valid && seg_ch.ready) || (cell_ch.valid && cell_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Receiver: random phases of full rate, random ready and a rotating pattern,
  // with a long hold-off whenever the sender asks for one.
  initial begin
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned mode;
    logic [7:0]  pat;
    hold_left  = 0;
    phase_left = 0;
    mode       = 0;
    pat        = 8'h5a;
    cell_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        cell_ch.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 2);
          phase_left = $urandom_range(10, 150);
          pat        = 8'($urandom);
          if (pat == 8'h00) pat = 8'h5a;
        end
        phase_left--;
        case (mode)
          0: cell_ch.ready <= 1'b1;
          1: cell_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            cell_ch.ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  // Offer one segment and hold it until the block takes it.
  task send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    seg_ch.valid   <= 1'b1;
    seg_ch.start_x <= sx;
    seg_ch.start_y <= sy;
    seg_ch.end_x   <= ex;
    seg_ch.end_y   <= ey;
    @(posedge clk_i);
    while (!seg_ch.ready) @(posedge clk_i);
  endtask

  // Between beats: carry on within a burst, else drop valid for a random gap.
  task pace_sender();
    int unsigned gap;
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      seg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task wait_drained();
    seg_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (cells_sb.pending() != 0) @(posedge clk_i);
  endtask

  task random_segment(output coord_t sx, output coord_t sy, output coord_t ex, output coord_t ey);
    int unsigned kind;
    int dx;
    int dy;
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      // park near the coordinate extremes so steep walks wrap
      sx = $urandom_range(0, 1) ? coord_t'(32767 - $urandom_range(0, 31))
                                : coord_t'(-32768 + int'($urandom_range(0, 31)));
      sy = $urandom_range(0, 1) ? coord_t'(32767 - $urandom_range(0, 31))
                                : coord_t'(-32768 + int'($urandom_range(0, 31)));
    end
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      ex = coord_t'($urandom);
      ey = coord_t'($urandom);
    end else begin
      if (kind < 16) begin
        dx = $urandom_range(0, 1) ? 31 + int'($urandom_range(0, 1))
                                  : -31 - int'($urandom_range(0, 1));
        dy = int'($urandom_range(0, 62)) - 31;
        if ($urandom_range(0, 1)) begin
          dy = dx;
          dx = int'($urandom_range(0, 62)) - 31;
        end
      end else if (kind < 45) begin
        dx = int'($urandom_range(0, 6)) - 3;
        dy = int'($urandom_range(0, 6)) - 3;
      end else begin
        dx = int'($urandom_range(0, 62)) - 31;
        dy = int'($urandom_range(0, 62)) - 31;
      end
      // an end that wraps becomes an oversized span, which is fine as noise
      ex = coord_t'(int'(sx) + dx);
      ey = coord_t'(int'(sy) + dy);
    end
  endtask

  initial begin
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    rst_ni         <= 1'b0;
    hold_req        = 1'b0;
    idle_cycles     = 0;
    burst_left      = 0;
    no_gap_left     = 0;
    seg_ch.valid   <= 1'b0;
    seg_ch.start_x <= '0;
    seg_ch.start_y <= '0;
    seg_ch.end_x   <= '0;
    seg_ch.end_y   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single points, including both corners of the grid
    send_segment(16'sd0, 16'sd0, 16'sd0, 16'sd0);                       pace_sender();
    send_segment(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);   pace_sender();
    send_segment(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);       pace_sender();
    // horizontal and vertical runs in both directions
    send_segment(16'sd5, 16'sd3, 16'sd12, 16'sd3);                      pace_sender();
    send_segment(16'sd12, -16'sd3, 16'sd5, -16'sd3);                    pace_sender();
    send_segment(16'sd7, -16'sd4, 16'sd7, 16'sd9);                      pace_sender();
    send_segment(16'sd7, 16'sd9, 16'sd7, -16'sd4);                      pace_sender();
    // shallow and steep slopes of either sign, walked from either end
    send_segment(16'sd0, 16'sd0, 16'sd10, 16'sd4);                      pace_sender();
    send_segment(16'sd10, 16'sd0, 16'sd0, 16'sd4);                      pace_sender();
    send_segment(16'sd0, 16'sd0, 16'sd3, 16'sd17);                      pace_sender();
    send_segment(16'sd3, 16'sd17, 16'sd0, 16'sd0);                      pace_sender();
    send_segment(-16'sd1, -16'sd1, 16'sd30, 16'sd0);                    pace_sender();
    // largest legal spans, and the steepest line that gives the most cells
    send_segment(16'sd0, 16'sd0, 16'sd31, 16'sd31);                     pace_sender();
    send_segment(16'sd100, 16'sd100, 16'sd69, 16'sd69);                 pace_sender();
    send_segment(-16'sd32768, 16'sd32767, -16'sd32737, 16'sd32736);     pace_sender();
    send_segment(16'sd0, 16'sd0, 16'sd1, 16'sd31);                      pace_sender();
    send_segment(16'sd0, 16'sd0, -16'sd1, -16'sd31);                    pace_sender();
    // overshoot past the end y, wrapping at the top and at the bottom
    send_segment(16'sd0, 16'sd32760, 16'sd1, 16'sd32767);               pace_sender();
    send_segment(16'sd0, -16'sd32761, 16'sd1, -16'sd32768);             pace_sender();
    // oversized spans, including ones that would look small if the difference wrapped
    send_segment(16'sd0, 16'sd0, 16'sd32, 16'sd0);                      pace_sender();
    send_segment(16'sd0, 16'sd0, 16'sd0, -16'sd32);                     pace_sender();
    send_segment(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);              pace_sender();
    send_segment(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);              pace_sender();
    send_segment(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    wait_drained();

    for (int unsigned i = 0; i < RANDOM_SEGS; i++) begin
      if (i == 120) begin
        // stall the output for a long stretch while segments keep coming
        hold_req    = 1'b1;
        no_gap_left = 16;
      end
      if (i == 260) wait_drained();
      random_segment(sx, sy, ex, ey);
      send_segment(sx, sy, ex, ey);
      pace_sender();
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (cells_sb.mismatches == 0 && cells_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
